// ----- rtl/core/cft_pkg.sv -----
// cft_pkg: shared types and character codes of the csv field tokenizer
// used by cft_step, csv_field_tokenizer and the testbench
`timescale 1ns / 1ps

package cft_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_PLAIN  = 3'd2,
        PH_QUOTED = 3'd3,
        PH_QSEEN  = 3'd4,
        PH_AFTERQ = 3'd5,
        PH_SKIP   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        K_DATA  = 3'd0,
        K_END   = 3'd1,
        K_LAST  = 3'd2,
        K_EMPTY = 3'd3,
        K_ERROR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_DANGLING   = 3'd1,
        ERR_GARBAGE    = 3'd2,
        ERR_ROW_OVF    = 3'd3,
        ERR_FIELDS_OVF = 3'd4
    } err_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [11:0] byte_position;
        logic [7:0]  field_index;
        logic [11:0] field_start;
        logic [12:0] field_length;
        err_t        error_code;
    } result_t;

endpackage

// ----- rtl/core/cft_ifs.sv -----
// cft_ifs: valid/ready channel interfaces of the csv field tokenizer
// byte input, token output and configuration write channels
`timescale 1ns / 1ps

interface cft_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface cft_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [11:0] byte_position;
    logic [7:0]  field_index;
    logic [11:0] field_start;
    logic [12:0] field_length;
    logic [2:0]  error_code;

    modport source (output valid, output kind, output data_byte, output byte_position,
                    output field_index, output field_start, output field_length,
                    output error_code, input ready);
    modport sink (input valid, input kind, input data_byte, input byte_position,
                  input field_index, input field_start, input field_length,
                  input error_code, output ready);
endinterface

interface cft_cfg_if;
    logic valid;
    logic ready;
    logic trim_spaces;

    modport source (output valid, output trim_spaces, input ready);
    modport sink (input valid, input trim_spaces, output ready);
endinterface

// ----- rtl/core/csv_field_tokenizer.sv -----
// csv_field_tokenizer: splits a byte stream into comma separated fields
// depends on cft_pkg, the cft_ifs interfaces and cft_step
//
//  channel  dir  payload                                       transaction
//  text     in   in_byte, end_of_stream                        one byte or end mark
//  tokens   out  kind, data_byte, byte_position, field_index,   zero or one per byte
//                field_start, field_length, error_code
//  cfg      in   trim_spaces                                   register write
//
// one byte per cycle while text.ready is high; the parse step is one level of logic between the
// state registers and a single output register
// text.ready is high while the output register is empty or being taken
// reset returns to the start of an empty row with trimming on
// cfg is always ready and takes effect for the next byte
`timescale 1ns / 1ps

module csv_field_tokenizer #(
    parameter int ROW_BYTES  = 4096,
    parameter int MAX_FIELDS = 256
) (
    input logic        clk,
    input logic        rst_n,
    cft_byte_if.sink   text,
    cft_token_if.source tokens,
    cft_cfg_if.sink    cfg
);

    localparam int PW = $clog2(ROW_BYTES + 1);
    localparam int AW = $clog2(ROW_BYTES);
    localparam int FW = $clog2(MAX_FIELDS);

    logic             trim_reg;
    cft_pkg::phase_t  phase_reg;
    cft_pkg::phase_t  phase_next;
    logic [PW-1:0]    wp_reg;
    logic [PW-1:0]    wp_next;
    logic [AW-1:0]    fb_reg;
    logic [AW-1:0]    fb_next;
    logic [PW-1:0]    ce_reg;
    logic [PW-1:0]    ce_next;
    logic [FW-1:0]    fc_reg;
    logic [FW-1:0]    fc_next;
    logic             swallow_reg;
    logic             swallow_next;
    logic             out_valid_reg;
    cft_pkg::result_t res_reg;
    cft_pkg::result_t res_next;
    logic             res_valid;
    logic             accept;

    cft_step #(
        .ROW_BYTES  (ROW_BYTES),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_step (
        .c            (text.in_byte),
        .eos          (text.end_of_stream),
        .trim         (trim_reg),
        .phase        (phase_reg),
        .wp           (wp_reg),
        .fb           (fb_reg),
        .ce           (ce_reg),
        .fc           (fc_reg),
        .swallow      (swallow_reg),
        .phase_next   (phase_next),
        .wp_next      (wp_next),
        .fb_next      (fb_next),
        .ce_next      (ce_next),
        .fc_next      (fc_next),
        .swallow_next (swallow_next),
        .res_valid    (res_valid),
        .res          (res_next)
    );

    assign text.ready = !out_valid_reg || tokens.ready;
    assign accept     = text.valid && text.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trim_reg <= 1'b1;
        else if (cfg.valid)
            trim_reg <= cfg.trim_spaces;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cft_pkg::PH_IDLE;
            wp_reg        <= '0;
            fb_reg        <= '0;
            ce_reg        <= '0;
            fc_reg        <= '0;
            swallow_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            fb_reg        <= fb_next;
            ce_reg        <= ce_next;
            fc_reg        <= fc_next;
            swallow_reg   <= swallow_next;
            out_valid_reg <= res_valid;
        end
        else if (tokens.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            res_reg <= res_next;
    end

    assign tokens.valid         = out_valid_reg;
    assign tokens.kind          = res_reg.kind;
    assign tokens.data_byte     = res_reg.data_byte;
    assign tokens.byte_position = res_reg.byte_position;
    assign tokens.field_index   = res_reg.field_index;
    assign tokens.field_start   = res_reg.field_start;
    assign tokens.field_length  = res_reg.field_length;
    assign tokens.error_code    = res_reg.error_code;

endmodule

// ----- rtl/core/cft_step.sv -----
// cft_step: next-state and result logic for one input byte
// depends on cft_pkg
`timescale 1ns / 1ps

module cft_step #(
    parameter int ROW_BYTES  = 4096,
    parameter int MAX_FIELDS = 256,
    localparam int PW = $clog2(ROW_BYTES + 1),
    localparam int AW = $clog2(ROW_BYTES),
    localparam int FW = $clog2(MAX_FIELDS)
) (
    input  logic [7:0]      c,
    input  logic            eos,
    input  logic            trim,
    input  cft_pkg::phase_t phase,
    input  logic [PW-1:0]   wp,
    input  logic [AW-1:0]   fb,
    input  logic [PW-1:0]   ce,
    input  logic [FW-1:0]   fc,
    input  logic            swallow,
    output cft_pkg::phase_t phase_next,
    output logic [PW-1:0]   wp_next,
    output logic [AW-1:0]   fb_next,
    output logic [PW-1:0]   ce_next,
    output logic [FW-1:0]   fc_next,
    output logic            swallow_next,
    output logic            res_valid,
    output cft_pkg::result_t res
);

    localparam logic [PW-1:0] ROW_LIMIT  = PW'(ROW_BYTES);
    localparam logic [FW-1:0] LAST_FIELD = FW'(MAX_FIELDS - 1);

    logic            is_space;
    logic            is_eol;
    logic            emit;
    logic            keeps;
    logic            comma;
    logic            row;
    logic            plain;
    logic            fail;
    cft_pkg::err_t   fail_code;
    logic            restart;
    logic            quote;
    logic            eos_err;
    logic [PW-1:0]   len;
    logic [PW-1:0]   wp_inc;

    assign is_space = (c == cft_pkg::CH_SPACE) || (c == cft_pkg::CH_TAB) ||
                      (c == cft_pkg::CH_FF) || (c == cft_pkg::CH_VT);
    assign is_eol   = (c == cft_pkg::CH_CR) || (c == cft_pkg::CH_LF);
    assign len      = ce - PW'(fb);
    assign wp_inc   = wp + PW'(1);

    // classify the byte against the parse phase
    always_comb
    begin
        emit         = 1'b0;
        keeps        = 1'b0;
        comma        = 1'b0;
        row          = 1'b0;
        plain        = 1'b0;
        fail         = 1'b0;
        fail_code    = cft_pkg::ERR_NONE;
        restart      = 1'b0;
        quote        = 1'b0;
        eos_err      = 1'b0;
        phase_next   = phase;
        swallow_next = swallow;
        if (eos)
        begin
            swallow_next = 1'b0;
            restart      = 1'b1;
            case (phase)
                cft_pkg::PH_QUOTED: eos_err = 1'b1;
                cft_pkg::PH_LEAD,
                cft_pkg::PH_PLAIN:
                begin
                    row   = 1'b1;
                    plain = 1'b1;
                end
                cft_pkg::PH_QSEEN,
                cft_pkg::PH_AFTERQ: row = 1'b1;
                default: ;
            endcase
        end
        else if (!(swallow && c == cft_pkg::CH_LF))
        begin
            swallow_next = 1'b0;
            if (is_eol && phase != cft_pkg::PH_QUOTED)
            begin
                if (c == cft_pkg::CH_CR)
                    swallow_next = 1'b1;
                if (phase == cft_pkg::PH_SKIP)
                    restart = 1'b1;
                else
                begin
                    row   = 1'b1;
                    plain = (phase == cft_pkg::PH_IDLE) || (phase == cft_pkg::PH_LEAD) ||
                            (phase == cft_pkg::PH_PLAIN);
                end
            end
            else
            begin
                case (phase)
                    cft_pkg::PH_IDLE,
                    cft_pkg::PH_LEAD:
                    begin
                        if (is_space)
                        begin
                            phase_next = cft_pkg::PH_LEAD;
                            emit       = !trim;
                            keeps      = 1'b1;
                        end
                        else if (c == cft_pkg::CH_QUOTE)
                            quote = 1'b1;
                        else if (c == cft_pkg::CH_COMMA)
                            comma = 1'b1;
                        else
                        begin
                            phase_next = cft_pkg::PH_PLAIN;
                            emit       = 1'b1;
                            keeps      = 1'b1;
                        end
                    end
                    cft_pkg::PH_PLAIN:
                    begin
                        if (c == cft_pkg::CH_COMMA)
                            comma = 1'b1;
                        else
                        begin
                            emit  = 1'b1;
                            keeps = !(is_space && trim);
                        end
                    end
                    cft_pkg::PH_QUOTED:
                    begin
                        if (c == cft_pkg::CH_QUOTE)
                            phase_next = cft_pkg::PH_QSEEN;
                        else
                        begin
                            emit  = 1'b1;
                            keeps = 1'b1;
                        end
                    end
                    cft_pkg::PH_QSEEN,
                    cft_pkg::PH_AFTERQ:
                    begin
                        if (c == cft_pkg::CH_QUOTE && phase == cft_pkg::PH_QSEEN)
                        begin
                            phase_next = cft_pkg::PH_QUOTED;
                            emit       = 1'b1;
                            keeps      = 1'b1;
                        end
                        else if (c == cft_pkg::CH_COMMA)
                            comma = 1'b1;
                        else if (is_space)
                            phase_next = cft_pkg::PH_AFTERQ;
                        else
                        begin
                            fail      = 1'b1;
                            fail_code = cft_pkg::ERR_GARBAGE;
                        end
                    end
                    default: phase_next = cft_pkg::PH_SKIP;
                endcase
            end
        end
        else
            swallow_next = 1'b0;

        // overflow checks
        if (emit && wp >= ROW_LIMIT)
        begin
            emit      = 1'b0;
            fail      = 1'b1;
            fail_code = cft_pkg::ERR_ROW_OVF;
        end
        if (comma && ce >= ROW_LIMIT)
        begin
            comma     = 1'b0;
            fail      = 1'b1;
            fail_code = cft_pkg::ERR_ROW_OVF;
        end
        else if (comma && fc == LAST_FIELD)
        begin
            comma     = 1'b0;
            fail      = 1'b1;
            fail_code = cft_pkg::ERR_FIELDS_OVF;
        end

        // phase overrides
        if (comma)
            phase_next = cft_pkg::PH_LEAD;
        if (quote)
            phase_next = cft_pkg::PH_QUOTED;
        if (fail)
            phase_next = cft_pkg::PH_SKIP;
        if (row || restart)
            phase_next = cft_pkg::PH_IDLE;
    end

    // apply the chosen action
    always_comb
    begin
        wp_next   = wp;
        fb_next   = fb;
        ce_next   = ce;
        fc_next   = fc;
        res_valid = 1'b0;
        res       = '0;
        res.field_index = 8'(fc);
        if (emit)
        begin
            res_valid         = 1'b1;
            res.kind          = cft_pkg::K_DATA;
            res.data_byte     = c;
            res.byte_position = 12'(wp);
            wp_next           = wp_inc;
            if (keeps)
                ce_next = wp_inc;
        end
        if (quote)
        begin
            wp_next = PW'(fb);
            ce_next = PW'(fb);
        end
        if (comma)
        begin
            res_valid        = 1'b1;
            res.kind         = cft_pkg::K_END;
            res.field_start  = 12'(fb);
            res.field_length = 13'(len);
            fc_next          = fc + FW'(1);
            fb_next          = AW'(ce);
            wp_next          = ce;
        end
        if (fail || eos_err)
        begin
            res_valid      = 1'b1;
            res.kind       = cft_pkg::K_ERROR;
            res.error_code = eos_err ? cft_pkg::ERR_DANGLING : fail_code;
        end
        if (row)
        begin
            res_valid = 1'b1;
            if (plain && fc == '0 && len == '0)
            begin
                res.kind        = cft_pkg::K_EMPTY;
                res.field_index = '0;
            end
            else
            begin
                res.kind         = cft_pkg::K_LAST;
                res.field_start  = 12'(fb);
                res.field_length = 13'(len);
            end
        end
        if (row || restart)
        begin
            wp_next = '0;
            fb_next = '0;
            ce_next = '0;
            fc_next = '0;
        end
    end

endmodule

// ----- sim/testbench.sv -----
// testbench: self-checking bench for csv_field_tokenizer, random byte streams and text rows
// carries its own predictor of the parser; depends on cft_pkg and the cft_ifs interfaces
`timescale 1ns / 1ps

module testbench;

    localparam int ROW_LIMIT   = 4096;
    localparam int FIELD_LIMIT = 256;

    typedef struct packed {
        logic [7:0] value;
        logic       eos;
    } text_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       text_valid = 1'b0;
    logic [7:0] text_byte = 8'h00;
    logic       text_eos = 1'b0;
    logic       take_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_trim = 1'b1;

    cft_byte_if  text_ch();
    cft_token_if token_ch();
    cft_cfg_if   cfg_ch();

    assign text_ch.valid = text_valid;
    assign text_ch.in_byte = text_byte;
    assign text_ch.end_of_stream = text_eos;
    assign token_ch.ready = take_ready;
    assign cfg_ch.valid = cfg_valid;
    assign cfg_ch.trim_spaces = cfg_trim;

    csv_field_tokenizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (token_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    text_item_t       pending_text[$];
    cft_pkg::result_t expected_tokens[$];
    int               mismatches = 0;
    bit               bursts_on = 1'b1;
    int               send_gap;
    int               take_stall;
    text_item_t       next_item;
    cft_pkg::result_t next_token;
    cft_pkg::result_t want;

    // parser state mirror
    cft_pkg::phase_t ps_phase;
    logic [12:0]     ps_wr;
    logic [11:0]     ps_begin;
    logic [12:0]     ps_end;
    logic [8:0]      ps_count;
    bit              ps_swallow_lf;
    bit              trim_model;

    function automatic bit is_blank(logic [7:0] c);
        return c == cft_pkg::CH_SPACE || c == cft_pkg::CH_TAB || c == cft_pkg::CH_FF ||
               c == cft_pkg::CH_VT;
    endfunction

    function automatic bit is_line_end(logic [7:0] c);
        return c == cft_pkg::CH_CR || c == cft_pkg::CH_LF;
    endfunction

    function automatic void restart_row();
        ps_phase = cft_pkg::PH_IDLE;
        ps_wr = 13'd0;
        ps_begin = 12'd0;
        ps_end = 13'd0;
        ps_count = 9'd0;
    endfunction

    function automatic cft_pkg::result_t make_token(cft_pkg::kind_t k, logic [7:0] d,
                                                    logic [11:0] pos, logic [11:0] st,
                                                    logic [12:0] len, cft_pkg::err_t e);
        cft_pkg::result_t t;
        t.kind = k;
        t.data_byte = d;
        t.byte_position = pos;
        t.field_index = (k == cft_pkg::K_EMPTY) ? 8'd0 : ps_count[7:0];
        t.field_start = st;
        t.field_length = len;
        t.error_code = e;
        return t;
    endfunction

    function automatic cft_pkg::result_t abort_row(cft_pkg::err_t e);
        ps_phase = cft_pkg::PH_SKIP;
        return make_token(cft_pkg::K_ERROR, 8'd0, 12'd0, 12'd0, 13'd0, e);
    endfunction

    function automatic cft_pkg::result_t store_byte(logic [7:0] c, bit keeps);
        logic [12:0] pos;
        pos = ps_wr;
        if (pos >= ROW_LIMIT)
            return abort_row(cft_pkg::ERR_ROW_OVF);
        ps_wr = pos + 13'd1;
        if (keeps)
            ps_end = ps_wr;
        return make_token(cft_pkg::K_DATA, c, pos[11:0], 12'd0, 13'd0, cft_pkg::ERR_NONE);
    endfunction

    function automatic cft_pkg::result_t close_field();
        logic [12:0] len;
        cft_pkg::result_t t;
        len = ps_end - {1'b0, ps_begin};
        if (ps_end >= ROW_LIMIT)
            return abort_row(cft_pkg::ERR_ROW_OVF);
        if (ps_count + 9'd1 >= FIELD_LIMIT)
            return abort_row(cft_pkg::ERR_FIELDS_OVF);
        t = make_token(cft_pkg::K_END, 8'd0, 12'd0, ps_begin, len, cft_pkg::ERR_NONE);
        ps_count = ps_count + 9'd1;
        ps_begin = ps_end[11:0];
        ps_wr = ps_end;
        ps_phase = cft_pkg::PH_LEAD;
        return t;
    endfunction

    function automatic cft_pkg::result_t close_line(bit plain);
        logic [12:0] len;
        cft_pkg::result_t t;
        len = ps_end - {1'b0, ps_begin};
        if (plain && ps_count == 9'd0 && len == 13'd0)
            t = make_token(cft_pkg::K_EMPTY, 8'd0, 12'd0, 12'd0, 13'd0, cft_pkg::ERR_NONE);
        else
            t = make_token(cft_pkg::K_LAST, 8'd0, 12'd0, ps_begin, len, cft_pkg::ERR_NONE);
        restart_row();
        return t;
    endfunction

    function automatic bit tokenize(logic [7:0] c, bit eos, output cft_pkg::result_t t);
        cft_pkg::phase_t ph;
        bit got;
        ph = ps_phase;
        got = 1'b1;
        t = '0;
        if (eos)
        begin
            ps_swallow_lf = 1'b0;
            if (ph == cft_pkg::PH_QUOTED)
                t = make_token(cft_pkg::K_ERROR, 8'd0, 12'd0, 12'd0, 13'd0,
                               cft_pkg::ERR_DANGLING);
            else if (ph == cft_pkg::PH_LEAD || ph == cft_pkg::PH_PLAIN)
                t = close_line(1'b1);
            else if (ph == cft_pkg::PH_QSEEN || ph == cft_pkg::PH_AFTERQ)
                t = close_line(1'b0);
            else
                got = 1'b0;
            restart_row();
            return got;
        end
        if (ps_swallow_lf)
        begin
            ps_swallow_lf = 1'b0;
            if (c == cft_pkg::CH_LF)
                return 1'b0;
        end
        if (is_line_end(c) && ph != cft_pkg::PH_QUOTED)
        begin
            if (c == cft_pkg::CH_CR)
                ps_swallow_lf = 1'b1;
            if (ph == cft_pkg::PH_SKIP)
            begin
                restart_row();
                return 1'b0;
            end
            t = close_line(ph == cft_pkg::PH_IDLE || ph == cft_pkg::PH_LEAD ||
                           ph == cft_pkg::PH_PLAIN);
            return 1'b1;
        end
        case (ph)
            cft_pkg::PH_IDLE, cft_pkg::PH_LEAD:
            begin
                if (is_blank(c))
                begin
                    ps_phase = cft_pkg::PH_LEAD;
                    if (trim_model)
                        got = 1'b0;
                    else
                        t = store_byte(c, 1'b1);
                end
                else if (c == cft_pkg::CH_QUOTE)
                begin
                    ps_wr = {1'b0, ps_begin};
                    ps_end = {1'b0, ps_begin};
                    ps_phase = cft_pkg::PH_QUOTED;
                    got = 1'b0;
                end
                else if (c == cft_pkg::CH_COMMA)
                    t = close_field();
                else
                begin
                    ps_phase = cft_pkg::PH_PLAIN;
                    t = store_byte(c, 1'b1);
                end
            end
            cft_pkg::PH_PLAIN:
            begin
                if (c == cft_pkg::CH_COMMA)
                    t = close_field();
                else
                    t = store_byte(c, !(is_blank(c) && trim_model));
            end
            cft_pkg::PH_QUOTED:
            begin
                if (c == cft_pkg::CH_QUOTE)
                begin
                    ps_phase = cft_pkg::PH_QSEEN;
                    got = 1'b0;
                end
                else
                    t = store_byte(c, 1'b1);
            end
            cft_pkg::PH_QSEEN:
            begin
                if (c == cft_pkg::CH_QUOTE)
                begin
                    ps_phase = cft_pkg::PH_QUOTED;
                    t = store_byte(c, 1'b1);
                end
                else if (c == cft_pkg::CH_COMMA)
                    t = close_field();
                else if (is_blank(c))
                begin
                    ps_phase = cft_pkg::PH_AFTERQ;
                    got = 1'b0;
                end
                else
                    t = abort_row(cft_pkg::ERR_GARBAGE);
            end
            cft_pkg::PH_AFTERQ:
            begin
                if (c == cft_pkg::CH_COMMA)
                    t = close_field();
                else if (is_blank(c))
                    got = 1'b0;
                else
                    t = abort_row(cft_pkg::ERR_GARBAGE);
            end
            default:
            begin
                ps_phase = cft_pkg::PH_SKIP;
                got = 1'b0;
            end
        endcase
        return got;
    endfunction

    function automatic void compare_field(string name, logic [15:0] exp_val,
                                          logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // byte driver and predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_byte <= 8'h00;
            text_eos <= 1'b0;
            send_gap = 0;
            restart_row();
            ps_swallow_lf = 1'b0;
            trim_model = 1'b1;
        end
        else
        begin
            if (text_valid && text_ch.ready)
            begin
                if (tokenize(text_byte, text_eos, next_token))
                    expected_tokens.push_back(next_token);
            end
            if (!text_valid || text_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    text_valid <= 1'b0;
                end
                else if (pending_text.size() != 0 && bursts_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 10);
                    text_valid <= 1'b0;
                end
                else if (pending_text.size() != 0)
                begin
                    next_item = pending_text.pop_front();
                    text_byte <= next_item.value;
                    text_eos <= next_item.eos;
                    text_valid <= 1'b1;
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    // token monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            take_stall = 0;
        end
        else
        begin
            if (token_ch.valid && take_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: expected no token, got kind %0d", $time, token_ch.kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    compare_field("kind", want.kind, token_ch.kind);
                    compare_field("data_byte", want.data_byte, token_ch.data_byte);
                    compare_field("byte_position", want.byte_position, token_ch.byte_position);
                    compare_field("field_index", want.field_index, token_ch.field_index);
                    compare_field("field_start", want.field_start, token_ch.field_start);
                    compare_field("field_length", want.field_length, token_ch.field_length);
                    compare_field("error_code", want.error_code, token_ch.error_code);
                end
            end
            if (take_stall > 0)
            begin
                take_stall = take_stall - 1;
                take_ready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 7) == 0)
            begin
                take_stall = $urandom_range(0, 10);
                take_ready <= 1'b0;
            end
            else
                take_ready <= 1'b1;
        end
    end

    task automatic push_byte(logic [7:0] b);
        pending_text.push_back('{b, 1'b0});
    endtask

    task automatic push_end();
        pending_text.push_back('{8'($urandom_range(0, 255)), 1'b1});
    endtask

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 3))
            0: return cft_pkg::CH_SPACE;
            1: return cft_pkg::CH_TAB;
            2: return cft_pkg::CH_FF;
            default: return cft_pkg::CH_VT;
        endcase
    endfunction

    function automatic logic [7:0] field_byte();
        logic [7:0] b;
        if ($urandom_range(0, 5) == 0)
            return any_blank();
        do
            b = 8'($urandom_range(0, 255));
        while (b == cft_pkg::CH_COMMA || b == cft_pkg::CH_CR || b == cft_pkg::CH_LF ||
               b == cft_pkg::CH_QUOTE);
        return b;
    endfunction

    task automatic queue_line_end();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            push_byte(cft_pkg::CH_CR);
            push_byte(cft_pkg::CH_LF);
        end
        else if (sel < 7)
            push_byte(cft_pkg::CH_LF);
        else if (sel < 9)
            push_byte(cft_pkg::CH_CR);
        else
            push_end();
    endtask

    task automatic queue_field();
        int style;
        int n;
        int pick;
        style = $urandom_range(0, 9);
        n = $urandom_range(0, 8);
        if (style < 5)
        begin
            repeat ($urandom_range(0, 2)) push_byte(any_blank());
            for (int i = 0; i < n; i++)
                push_byte((i > 0 && $urandom_range(0, 15) == 0) ? cft_pkg::CH_QUOTE
                                                                 : field_byte());
            repeat ($urandom_range(0, 2)) push_byte(any_blank());
        end
        else if (style < 9)
        begin
            repeat ($urandom_range(0, 2)) push_byte(any_blank());
            push_byte(cft_pkg::CH_QUOTE);
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    push_byte(cft_pkg::CH_QUOTE);
                    push_byte(cft_pkg::CH_QUOTE);
                end
                else if (pick == 1)
                    push_byte(cft_pkg::CH_COMMA);
                else if (pick == 2)
                    push_byte($urandom_range(0, 1) ? cft_pkg::CH_CR : cft_pkg::CH_LF);
                else
                    push_byte(field_byte());
            end
            push_byte(cft_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 2)) push_byte(any_blank());
        end
    endtask

    task automatic queue_row();
        int sel;
        int nf;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            queue_line_end();
        else if (sel == 1)
        begin
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
            queue_line_end();
        end
        else if (sel == 2)
        begin
            push_byte(cft_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 4)) push_byte(field_byte());
            if ($urandom_range(0, 1))
                push_end();
            else
            begin
                push_byte(cft_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 1)) push_byte(any_blank());
                push_byte(8'($urandom_range(8'h41, 8'h7A)));
                repeat ($urandom_range(0, 4)) push_byte(field_byte());
                queue_line_end();
            end
        end
        else
        begin
            nf = $urandom_range(1, 6);
            for (int f = 0; f < nf; f++)
            begin
                if (f > 0)
                    push_byte(cft_pkg::CH_COMMA);
                queue_field();
            end
            queue_line_end();
        end
    endtask

    task automatic queue_random(int count);
        int target;
        target = pending_text.size() + count;
        while (pending_text.size() < target)
            queue_row();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_text.size() != 0 || text_valid || expected_tokens.size() != 0);
    endtask

    task automatic write_trim(bit value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_trim <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        trim_model = value;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_trim(1'b1);
        // trimmed field, quoted field with escapes, comma and CR inside, blank after quote
        push_byte(cft_pkg::CH_TAB);
        push_byte("a");
        push_byte(cft_pkg::CH_FF);
        push_byte(cft_pkg::CH_COMMA);
        push_byte(cft_pkg::CH_QUOTE);
        push_byte("x");
        push_byte(cft_pkg::CH_QUOTE);
        push_byte(cft_pkg::CH_QUOTE);
        push_byte(cft_pkg::CH_COMMA);
        push_byte(cft_pkg::CH_CR);
        push_byte(cft_pkg::CH_QUOTE);
        push_byte(cft_pkg::CH_VT);
        push_byte(cft_pkg::CH_COMMA);
        // quote inside unquoted field, byte extremes, CR LF
        push_byte(8'hFF);
        push_byte(cft_pkg::CH_QUOTE);
        push_byte(8'h00);
        push_byte(cft_pkg::CH_CR);
        push_byte(cft_pkg::CH_LF);
        // blank line, quoted empty field
        push_byte(cft_pkg::CH_LF);
        push_byte(cft_pkg::CH_QUOTE);
        push_byte(cft_pkg::CH_QUOTE);
        push_byte(cft_pkg::CH_LF);
        // garbage after closing quote, rest of row skipped
        push_byte(cft_pkg::CH_QUOTE);
        push_byte("a");
        push_byte(cft_pkg::CH_QUOTE);
        push_byte("x");
        push_byte(cft_pkg::CH_COMMA);
        push_byte(cft_pkg::CH_LF);
        // end of stream inside quotes, then with nothing open
        push_byte(cft_pkg::CH_QUOTE);
        push_end();
        push_end();

        write_trim(1'b0);
        // leading blanks before a quote get overwritten
        push_byte(cft_pkg::CH_SPACE);
        push_byte(cft_pkg::CH_SPACE);
        push_byte(cft_pkg::CH_QUOTE);
        push_byte("q");
        push_byte(cft_pkg::CH_QUOTE);
        push_end();
        // trailing blank kept, then end of stream while skipping
        push_byte("a");
        push_byte(cft_pkg::CH_SPACE);
        push_byte(cft_pkg::CH_COMMA);
        push_byte(cft_pkg::CH_QUOTE);
        push_byte("b");
        push_byte(cft_pkg::CH_QUOTE);
        push_byte("z");
        push_end();
        queue_random(300);

        write_trim(1'b1);
        queue_random(350);
        repeat (FIELD_LIMIT) push_byte(cft_pkg::CH_COMMA);
        push_byte(cft_pkg::CH_LF);

        write_trim(1'b0);
        queue_random(350);

        write_trim(1'b1);
        bursts_on = 1'b0;
        queue_random(450);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
